FILE: rtl/ssf_pkg.sv
// Shared types, constants and selection helpers for the shortest-seek-first scheduler.
// No dependencies; every other file imports this package.
package ssf_pkg;

   localparam int TrackW = 8;
   localparam int SlotOutW = 6;
   localparam int DistW = 9;
   localparam int GroupLanes = 8;
   localparam int MaxRequestsDef = 32;
   localparam int NumTracks = 256;
   localparam int TrackTopInt = (NumTracks - 1 > 255) ? 255 : NumTracks - 1;
   localparam logic [TrackW-1:0] TrackTop = TrackW'(TrackTopInt);
   localparam logic [DistW-1:0] NoDistance = DistW'(NumTracks + 2);

   typedef struct packed {
      logic              command;
      logic [TrackW-1:0] position;
   } req_type;

   typedef struct packed {
      logic [TrackW-1:0]   served_position;
      logic [SlotOutW-1:0] request_slot;
      logic                last_served;
   } rsp_type;

   typedef struct packed {
      logic [DistW-1:0]  seek_dist;
      logic [2:0]        lidx;
      logic [TrackW-1:0] pos;
   } cand_type;

   typedef enum logic [1:0] {
      StIdle,
      StGroup,
      StPick
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic group;
      logic pick;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic last_pick;
   } ctrl_status_type;

   // Index of the smallest distance among eight; the higher index wins a tie.
   function automatic logic [2:0] argmin8(input cand_type [7:0] c);
      logic [DistW-1:0] d1 [4];
      logic [2:0]       s1 [4];
      logic [DistW-1:0] d2 [2];
      logic [2:0]       s2 [2];
      logic [2:0]       sel;
      for (int i = 0; i < 4; i++) begin
         if (c[2*i+1].seek_dist <= c[2*i].seek_dist) begin
            d1[i] = c[2*i+1].seek_dist;
            s1[i] = 3'(2*i+1);
         end else begin
            d1[i] = c[2*i].seek_dist;
            s1[i] = 3'(2*i);
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (d1[2*i+1] <= d1[2*i]) begin
            d2[i] = d1[2*i+1];
            s2[i] = s1[2*i+1];
         end else begin
            d2[i] = d1[2*i];
            s2[i] = s1[2*i];
         end
      end
      if (d2[1] <= d2[0]) begin
         sel = s2[1];
      end else begin
         sel = s2[0];
      end
      return sel;
   endfunction

endpackage

FILE: rtl/ssf_ctrl.sv
// Sequencer for the shortest-seek-first scheduler: loads, start and the select loop.
// Depends on ssf_pkg; drives ssf_datapath through command and status structs.
module ssf_ctrl
   import ssf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            command,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         StIdle: begin
            if (start) begin
               if (command) begin
                  cmd.start = 1'b1;
                  if (!status.count_zero) begin
                     state_in = StGroup;
                  end
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         StGroup: begin
            cmd.group = 1'b1;
            state_in = StPick;
         end
         StPick: begin
            cmd.pick = 1'b1;
            state_in = status.last_pick ? StIdle : StGroup;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   assign busy = (state_ff != StIdle);

`ifndef SYNTHESIS
   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy |-> !status.count_zero)
      else $error("scheduler busy with an empty table");

   a_pick_after_group: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> $past(cmd.group))
      else $error("pick without a preceding group pass");

   a_last_ends_batch: assert property (@(posedge clock) disable iff (reset)
      (cmd.pick && status.last_pick) |=> !busy)
      else $error("batch did not end after the last pick");
`endif

endmodule

FILE: rtl/ssf_datapath.sv
// Request table, served flags, head register, two-level distance argmin and result register.
// Depends on ssf_pkg; controlled by ssf_ctrl.
module ssf_datapath
   import ssf_pkg::*;
#(
   parameter int MAX_REQUESTS = MaxRequestsDef
)(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   input  logic [TrackW-1:0] req_position,
   output ctrl_status_type   status,
   output logic              rsp_strobe,
   output rsp_type           rsp_data
);

   localparam int CntW = $clog2(MAX_REQUESTS + 1);
   localparam int NumGroups = (MAX_REQUESTS + GroupLanes - 1) / GroupLanes;

   logic [TrackW-1:0] store_ff [MAX_REQUESTS];
   logic [MAX_REQUESTS-1:0] served_ff;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] rem_ff;
   logic [TrackW-1:0] head_ff;
   logic rsp_strobe_ff;
   rsp_type rsp_data_ff;

   logic [TrackW-1:0] pos_clamped;
   logic load_ok;
   logic finish;
   cand_type [7:0][7:0] lane_c;
   cand_type [7:0] grp_c;
   logic [2:0] gsel;
   cand_type win;
   logic [SlotOutW-1:0] win_slot;

   assign pos_clamped = (req_position > TrackTop) ? TrackTop : req_position;
   assign load_ok = cmd.load && (count_ff != CntW'(MAX_REQUESTS));
   assign status.count_zero = (count_ff == '0);
   assign status.last_pick = (rem_ff == CntW'(1));
   assign finish = cmd.pick && status.last_pick;

   // Distance of every pending lane to the head; empty or served lanes never win.
   for (genvar g = 0; g < 64; g++) begin : g_lane
      if (g < MAX_REQUESTS) begin : g_real
         logic pending;
         assign pending = (count_ff > CntW'(g)) && !served_ff[g];
         assign lane_c[g/8][g%8].seek_dist = !pending ? NoDistance :
            (store_ff[g] >= head_ff) ? DistW'(store_ff[g] - head_ff)
                                     : DistW'(head_ff - store_ff[g]);
         assign lane_c[g/8][g%8].lidx = '0;
         assign lane_c[g/8][g%8].pos = store_ff[g];
      end else begin : g_pad
         assign lane_c[g/8][g%8] = '{seek_dist: NoDistance, lidx: '0, pos: '0};
      end
   end

   // First level: best lane of each group of eight, registered.
   for (genvar g = 0; g < 8; g++) begin : g_group
      if (g < NumGroups) begin : g_real
         cand_type grp_ff;
         cand_type grp_in;
         logic [2:0] lsel;
         always_comb begin
            lsel = argmin8(lane_c[g]);
            grp_in = lane_c[g][lsel];
            grp_in.lidx = lsel;
         end
         always_ff @(posedge clock) begin
            if (cmd.group) begin
               grp_ff <= grp_in;
            end
         end
         assign grp_c[g] = grp_ff;
      end else begin : g_pad
         assign grp_c[g] = '{seek_dist: NoDistance, lidx: '0, pos: '0};
      end
   end

   // Second level: best group, then slot = group and lane within it.
   assign gsel = argmin8(grp_c);
   assign win = grp_c[gsel];
   assign win_slot = {gsel, win.lidx};

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_REQUESTS; i++) begin
         if (load_ok && (count_ff == CntW'(i))) begin
            store_ff[i] <= pos_clamped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         served_ff <= '0;
         count_ff <= '0;
         rem_ff <= '0;
         head_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.pick;
         if (finish) begin
            served_ff <= '0;
            count_ff <= '0;
         end else begin
            for (int i = 0; i < MAX_REQUESTS; i++) begin
               if (load_ok && (count_ff == CntW'(i))) begin
                  served_ff[i] <= 1'b0;
               end
               if (cmd.pick && (win_slot == SlotOutW'(i))) begin
                  served_ff[i] <= 1'b1;
               end
            end
            if (load_ok) begin
               count_ff <= count_ff + CntW'(1);
            end
         end
         if (cmd.start) begin
            head_ff <= pos_clamped;
            rem_ff <= count_ff;
         end else if (cmd.pick) begin
            head_ff <= win.pos;
            rem_ff <= rem_ff - CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         rsp_data_ff.served_position <= win.pos;
         rsp_data_ff.request_slot <= win_slot;
         rsp_data_ff.last_served <= status.last_pick;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_strobe_from_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(cmd.pick))
      else $error("result strobe without a pick");

   a_pick_has_winner: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> (win.seek_dist != NoDistance))
      else $error("pick found no pending request");

   a_last_clears_table: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_data_ff.last_served) |-> (count_ff == '0))
      else $error("table not cleared after the last result");
`endif

endmodule

FILE: rtl/shortest_seek_first_scheduler.sv
// Shortest-seek-first scheduler: a load stays in idle and busy stays low.
// A start with N stored requests holds busy for N rounds (group argmin, then final pick);
// each pick registers one result onto the ports, so the results follow one per round.
// A start on an empty table only takes the head and gives no result; results cannot stall.
// Synchronous reset empties the table, clears the served flags and sets the head to zero.
module shortest_seek_first_scheduler
   import ssf_pkg::*;
#(
   parameter int MAX_REQUESTS = MaxRequestsDef
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   ssf_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_data.command),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   ssf_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_position (req_data.position),
      .status       (status),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

endmodule
